// ===== sv/uartrx_pkg.sv =====
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared constants for the UART receive FIFO and status register block.
// ----------------------------------------------------------------------------
package uartrx_pkg;

  // Ring size; holds FIFO_DEPTH-1 bytes at most.
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  localparam int unsigned BYTE_W = 8;

  // Item operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [7:0] DATA_OFFSET = 8'h8D;
  localparam logic [7:0] EMPTY_READ  = 8'h00;

  // Control bits
  localparam logic [7:0] CTL_TXINTEN  = 8'h80;
  localparam logic [7:0] CTL_RXINTEN  = 8'h40;
  localparam logic [7:0] CTL_RESETERR = 8'h08;

  // Status bits
  localparam logic [7:0] ST_TXRDY   = 8'h80;
  localparam logic [7:0] ST_RXRDY   = 8'h40;
  localparam logic [7:0] ST_TXEMPTY = 8'h20;
  localparam logic [7:0] ST_OVERRUN = 8'h08;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ===== sv/uartrx_ram.sv =====
// ----------------------------------------------------------------------------
// uartrx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uartrx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/uart_rx_fifo_status_regs.sv =====
// ----------------------------------------------------------------------------
// uart_rx_fifo_status_regs
// UART register block: receive ring FIFO, control and status registers.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: a word (in_op, in_reg_offset, in_data_in) is taken at a
//   rising edge with start high and busy low. in_op selects a link byte push,
//   a bus read or a bus write; offset 0x8D is the data register, any other
//   offset the control/status register.
//   Result channel: exactly one result word per input word, shown for one
//   cycle with out_valid high. The receiver cannot hold results off.
//   Latency: the result appears in the cycle after the accepting edge.
//   Throughput: one word per cycle. The receive store is a RAM with a
//   registered read port; a pop reads it at the accepting edge and the byte
//   is routed to out_read_data straight from the RAM output, so no extra
//   cycle is needed. A push and a later pop of the same slot are always in
//   different cycles, and the write lands before the read, so no forwarding
//   path is needed. busy therefore stays low.
//   Reset: pointers, control register and overrun flag clear synchronously; the
//   RAM itself is not cleared (only written slots are ever read).
// ----------------------------------------------------------------------------
module uart_rx_fifo_status_regs
  import uartrx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_reg_offset,
  input  logic [BYTE_W-1:0] in_data_in,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_read_data,
  output logic              out_tx_valid,
  output logic [BYTE_W-1:0] out_tx_byte,
  output logic              out_irq_pulse
);

  // Architectural state
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic              ovr_r, ovr_nxt;

  // Result registers
  logic              vld_r;
  logic              pop_r, pop_nxt;
  logic [BYTE_W-1:0] rdat_r, rdat_nxt;
  logic              txv_r, txv_nxt;
  logic [BYTE_W-1:0] txb_r, txb_nxt;
  logic              irq_r, irq_nxt;

  // RAM side
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_q;

  logic              accept;
  logic              has_data;
  logic              is_data;
  logic [PTR_W-1:0]  wr_next, rd_next;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign has_data = (rd_ptr_r != wr_ptr_r);
  assign is_data  = (in_reg_offset == DATA_OFFSET);
  assign wr_next  = ring_next(wr_ptr_r);
  assign rd_next  = ring_next(rd_ptr_r);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    ctrl_nxt   = ctrl_r;
    ovr_nxt    = ovr_r;
    pop_nxt    = 1'b0;
    rdat_nxt   = '0;
    txv_nxt    = 1'b0;
    txb_nxt    = '0;
    irq_nxt    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (accept) begin
      case (in_op)
        OP_PUSH: begin
          if (wr_next == rd_ptr_r) begin
            ovr_nxt = 1'b1;                    // full: drop the byte
          end else begin
            ram_we     = 1'b1;
            wr_ptr_nxt = wr_next;
            irq_nxt    = |(ctrl_r & CTL_RXINTEN);
          end
        end
        OP_READ: begin
          if (is_data) begin
            if (has_data) begin
              ram_re     = 1'b1;
              pop_nxt    = 1'b1;
              rd_ptr_nxt = rd_next;
              irq_nxt    = (rd_next != wr_ptr_r) && |(ctrl_r & CTL_RXINTEN);
            end else begin
              rdat_nxt = EMPTY_READ;
            end
          end else begin
            rdat_nxt = ST_TXRDY | ST_TXEMPTY
                     | (has_data ? ST_RXRDY : 8'h00)
                     | (ovr_r ? ST_OVERRUN : 8'h00);
          end
        end
        OP_WRITE: begin
          if (is_data) begin
            txv_nxt = 1'b1;
            txb_nxt = in_data_in;
            irq_nxt = |(ctrl_r & CTL_TXINTEN);
          end else begin
            ctrl_nxt = in_data_in;
            if (|(in_data_in & CTL_RESETERR)) begin
              ovr_nxt = 1'b0;
            end
            irq_nxt = has_data && |(in_data_in & CTL_RXINTEN);
          end
        end
        default: begin
          // unused code: no effect, all-zero result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      ctrl_r   <= '0;
      ovr_r    <= 1'b0;
      vld_r    <= 1'b0;
      pop_r    <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      ctrl_r   <= ctrl_nxt;
      ovr_r    <= ovr_nxt;
      vld_r    <= accept;
      pop_r    <= pop_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    rdat_r <= rdat_nxt;
    txv_r  <= txv_nxt;
    txb_r  <= txb_nxt;
    irq_r  <= irq_nxt;
  end

  // Receive store
  uartrx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_data_in),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_q)
  );

  assign out_valid     = vld_r;
  assign out_read_data = pop_r ? ram_q : rdat_r;
  assign out_tx_valid  = vld_r && txv_r;
  assign out_tx_byte   = vld_r ? txb_r : '0;
  assign out_irq_pulse = vld_r && irq_r;

  // Checks
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_pop_is_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop_r |-> vld_r)
    else $error("pop data presented without a result strobe");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_PUSH && wr_next == rd_ptr_r) |=>
      ($stable(wr_ptr_r) && ovr_r))
    else $error("push onto full ring moved the write pointer");

  a_tx_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tx_valid |-> (!pop_r && out_read_data == '0))
    else $error("transmit result carries read data");

  a_no_ram_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("RAM written and read in the same cycle");

endmodule

// ===== verif/uart_rx_fifo_status_regs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_fifo_status_regs_chk
// Watches the word and result channels of the UART register block, keeps a
// shadow of the receive ring, control byte and overrun flag, and checks every
// result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module uart_rx_fifo_status_regs_chk
  import uartrx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_reg_offset,
  input  logic [BYTE_W-1:0] in_data_in,
  input  logic              out_valid,
  input  logic [BYTE_W-1:0] out_read_data,
  input  logic              out_tx_valid,
  input  logic [BYTE_W-1:0] out_tx_byte,
  input  logic              out_irq_pulse,
  output int                fail_count,
  output int                pending_words
);

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              irq_pulse;
  } reply_t;

  logic [BYTE_W-1:0] ctl_shadow;
  logic              ovr_shadow;
  logic [BYTE_W-1:0] ring [FIFO_DEPTH];
  int unsigned       head;   // oldest byte
  int unsigned       tail;   // next free slot
  reply_t            replies_due[$];
  int                mismatches = 0;

  function automatic int unsigned slot_after(input int unsigned s);
    return (s + 1) % FIFO_DEPTH;
  endfunction

  function automatic logic rx_irq_due();
    return (head != tail) && ((ctl_shadow & CTL_RXINTEN) != '0);
  endfunction

  // updates the shadow state and returns the reply the block owes
  function automatic reply_t apply_word(input logic [1:0] op, input logic [7:0] offset,
                                        input logic [BYTE_W-1:0] data);
    reply_t r;
    logic [BYTE_W-1:0] st;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (slot_after(tail) == head) begin
          ovr_shadow = 1'b1;
        end else begin
          ring[tail] = data;
          tail = slot_after(tail);
          r.irq_pulse = rx_irq_due();
        end
      end
      OP_READ: begin
        if (offset == DATA_OFFSET) begin
          if (head == tail) begin
            r.read_data = EMPTY_READ;
          end else begin
            r.read_data = ring[head];
            head = slot_after(head);
            r.irq_pulse = rx_irq_due();
          end
        end else begin
          st = ST_TXRDY | ST_TXEMPTY;
          if (head != tail) st = st | ST_RXRDY;
          if (ovr_shadow) st = st | ST_OVERRUN;
          r.read_data = st;
        end
      end
      OP_WRITE: begin
        if (offset == DATA_OFFSET) begin
          r.tx_valid  = 1'b1;
          r.tx_byte   = data;
          r.irq_pulse = (ctl_shadow & CTL_TXINTEN) != '0;
        end else begin
          ctl_shadow = data;
          if ((data & CTL_RESETERR) != '0) ovr_shadow = 1'b0;
          r.irq_pulse = rx_irq_due();
        end
      end
      default: ;  // unused op: no state change, all-zero reply
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[chk] %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      ctl_shadow = '0;
      ovr_shadow = 1'b0;
      head = 0;
      tail = 0;
      replies_due.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with nothing due", 0, 0);
        end else begin
          want = replies_due.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
          if (out_tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", out_tx_valid, want.tx_valid);
          if (out_tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", out_tx_byte, want.tx_byte);
          if (out_irq_pulse !== want.irq_pulse)
            report_mismatch("irq_pulse", out_irq_pulse, want.irq_pulse);
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        replies_due.push_back(apply_word(in_op, in_reg_offset, in_data_in));
    end
    fail_count    <= mismatches;
    pending_words <= replies_due.size();
  end

endmodule

// ===== verif/tb_uart_rx_fifo_status_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_fifo_status_regs
// Stimulus and verdict for the UART receive FIFO / status register block.
// A short directed run covers status and data reads, both write targets, the
// unused op and the interrupt enables; random phases then fill the ring past
// full, drain it past empty and mix bus traffic, with idle bursts on the
// word side. Checking lives in the companion checker module.
// ----------------------------------------------------------------------------
module tb_uart_rx_fifo_status_regs;
  import uartrx_pkg::*;

  localparam int         WORD_TARGET = 1550;
  localparam int         CALM_TAIL   = 200;     // last words go back to back
  localparam int         CYCLE_LIMIT = 400000;  // cycles before the watchdog ends the run
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  logic [1:0]        in_op         = '0;
  logic [7:0]        in_reg_offset = '0;
  logic [BYTE_W-1:0] in_data_in    = '0;
  logic              out_valid;
  logic [BYTE_W-1:0] out_read_data;
  logic              out_tx_valid;
  logic [BYTE_W-1:0] out_tx_byte;
  logic              out_irq_pulse;

  int fail_count;
  int pending_words;
  int sent_words  = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;   // phase with no idling at all

  uart_rx_fifo_status_regs DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_reg_offset (in_reg_offset),
    .in_data_in    (in_data_in),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_irq_pulse (out_irq_pulse)
  );

  uart_rx_fifo_status_regs_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_reg_offset (in_reg_offset),
    .in_data_in    (in_data_in),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_irq_pulse (out_irq_pulse),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[uart_rx_fifo_status_regs] ERROR");
      $finish;
    end
  end

  // any control/status offset, never the data register
  function automatic logic [7:0] ctl_offset();
    logic [7:0] o;
    o = 8'($urandom_range(0, 255));
    if (o == DATA_OFFSET) o = ~DATA_OFFSET;
    return o;
  endfunction

  // drop start for a random burst now and then, except in calm phases and near the end
  task automatic maybe_pause();
    if (!calm && sent_words < WORD_TARGET - CALM_TAIL && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // present one word and hold it until the block takes it
  task automatic send_word(input logic [1:0] op, input logic [7:0] offset,
                           input logic [BYTE_W-1:0] data);
    in_op         <= op;
    in_reg_offset <= offset;
    in_data_in    <= data;
    start         <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (op != OP_UNUSED) sent_words++;
    maybe_pause();
  endtask

  // one word of mixed bus and link traffic
  task automatic mixed_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      send_word(OP_PUSH, 8'($urandom), 8'($urandom));
    else if (pick < 60) send_word(OP_READ, DATA_OFFSET, 8'($urandom));
    else if (pick < 70) send_word(OP_READ, ctl_offset(), 8'($urandom));
    else if (pick < 80) send_word(OP_WRITE, DATA_OFFSET, 8'($urandom));
    else if (pick < 95) send_word(OP_WRITE, ctl_offset(), 8'($urandom));
    else                send_word(OP_UNUSED, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int phase;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    send_word(OP_READ,  8'h00,       8'h00);          // status, ring empty
    send_word(OP_READ,  DATA_OFFSET, 8'h00);          // pop from empty ring -> 0
    send_word(OP_WRITE, 8'h00,       8'hFF);          // all enables + error clear
    send_word(OP_PUSH,  8'h00,       8'h00);          // stored, RX irq
    send_word(OP_PUSH,  8'hFF,       8'hFF);
    send_word(OP_READ,  8'hFF,       8'hFF);          // status shows RX ready
    send_word(OP_READ,  DATA_OFFSET, 8'h00);          // pop, one left -> irq
    send_word(OP_READ,  DATA_OFFSET, 8'hFF);          // last pop, no irq
    send_word(OP_WRITE, DATA_OFFSET, 8'hFF);          // transmit, TX irq
    send_word(OP_WRITE, DATA_OFFSET, 8'h00);
    send_word(OP_WRITE, 8'h8C,       8'h00);          // enables off
    send_word(OP_WRITE, DATA_OFFSET, 8'h5A);          // transmit, no irq
    send_word(OP_UNUSED, DATA_OFFSET, 8'hA5);         // ignored op
    send_word(OP_UNUSED, 8'h00,      8'hFF);
    send_word(OP_PUSH,  8'h8D,       8'h81);          // no irq, RX disabled
    send_word(OP_WRITE, 8'h8E,       CTL_RXINTEN);    // enable with data waiting
    send_word(OP_WRITE, 8'h01,       CTL_TXINTEN | CTL_RESETERR);
    send_word(OP_READ,  8'h8C,       8'h00);
    send_word(OP_READ,  8'h8E,       8'h00);
    send_word(OP_READ,  DATA_OFFSET, 8'h00);

    // --- random phases ---
    while (sent_words < WORD_TARGET) begin
      phase = $urandom_range(0, 9);
      calm  = ($urandom_range(0, 2) == 0);
      case (phase)
        0, 1: begin
          // fill, often past full: overrun and pointer wrap
          n = $urandom_range(200, 270);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_word(OP_READ, ctl_offset(), 8'($urandom));
            else                           send_word(OP_PUSH, 8'($urandom), 8'($urandom));
          end
        end
        2, 3: begin
          // drain, often past empty
          n = $urandom_range(1, 300);
          repeat (n) send_word(OP_READ, DATA_OFFSET, 8'($urandom));
        end
        4, 5, 6: begin
          n = $urandom_range(1, 40);
          repeat (n) mixed_word();
        end
        7: begin
          // noise: any field value at all
          n = $urandom_range(1, 20);
          repeat (n) send_word(2'($urandom), 8'($urandom), 8'($urandom));
        end
        default: begin
          send_word(OP_WRITE, ctl_offset(), 8'($urandom));
          send_word(OP_READ,  ctl_offset(), 8'($urandom));
        end
      endcase
    end

    start <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[uart_rx_fifo_status_regs] OK");
    end else begin
      $display("[uart_rx_fifo_status_regs] ERROR");
    end
    $finish;
  end

endmodule
